[hw/rtl/csrmv_pkg.sv]
// ----------------------------------------------------------------------------
// csrmv_pkg
// shared types, function codes and default sizes of the sparse matvec block
// ----------------------------------------------------------------------------
package csrmv_pkg;

    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int OPERAND_BITS_DEF = 16;
    localparam int ACC_BITS_DEF     = 40;

    localparam int FUNC_BITS    = 2;
    localparam int INDEX_BITS   = 10;
    localparam int VALUE_BITS   = 16;
    localparam int ROW_SUM_BITS = 40;
    localparam int ROW_NUM_BITS = 16;

    localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_NONZERO = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_EMPTY   = 2'd2;

    typedef struct packed {
        logic [FUNC_BITS-1:0]         func;
        logic [INDEX_BITS-1:0]        index;
        logic signed [VALUE_BITS-1:0] value;
        logic                         row_end;
    } in_word_t;

    typedef struct packed {
        logic signed [ROW_SUM_BITS-1:0] row_sum;
        logic [ROW_NUM_BITS-1:0]        row_number;
        logic                           saturated;
    } out_word_t;

    typedef struct packed {
        logic                 valid;
        logic [FUNC_BITS-1:0] func;
        logic                 row_end;
    } stage_ctrl_t;

endpackage

[hw/rtl/csrmv_ram.sv]
// ----------------------------------------------------------------------------
// csrmv_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module csrmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/csrmv_mul.sv]
// ----------------------------------------------------------------------------
// csrmv_mul
// product stage: matrix value times looked-up vector entry, registered
// ----------------------------------------------------------------------------
module csrmv_mul #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  csrmv_pkg::stage_ctrl_t         in_ctrl,
    input  logic [OPERAND_BITS-1:0]        in_value,
    input  logic [OPERAND_BITS-1:0]        in_entry,
    input  logic                           in_hit,
    output csrmv_pkg::stage_ctrl_t         out_ctrl,
    output logic signed [2*OPERAND_BITS-1:0] out_product
);
    import csrmv_pkg::*;

    logic signed [OPERAND_BITS-1:0]   entry;
    logic signed [2*OPERAND_BITS-1:0] product_next;
    logic signed [2*OPERAND_BITS-1:0] product_reg;
    stage_ctrl_t                      ctrl_reg;

    // out-of-range column reads as zero
    assign entry        = in_hit ? $signed(in_entry) : '0;
    assign product_next = $signed(in_value) * entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= product_next;
        end
    end

    assign out_ctrl    = ctrl_reg;
    assign out_product = product_reg;

endmodule

[hw/rtl/csrmv_acc.sv]
// ----------------------------------------------------------------------------
// csrmv_acc
// saturating row accumulator, row counter and output word register
// ----------------------------------------------------------------------------
module csrmv_acc #(
    parameter int OPERAND_BITS = 16,
    parameter int ACC_BITS     = 40
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  csrmv_pkg::stage_ctrl_t           in_ctrl,
    input  logic signed [2*OPERAND_BITS-1:0] in_product,
    output logic                             hold,
    output logic                             m_valid,
    input  logic                             m_ready,
    output csrmv_pkg::out_word_t             m_word
);
    import csrmv_pkg::*;

    localparam int PROD_BITS = 2 * OPERAND_BITS;
    localparam int SUM_BITS  = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
    localparam logic signed [SUM_BITS-1:0] ACC_MAX =
        SUM_BITS'({1'b0, {(ACC_BITS-1){1'b1}}});
    localparam logic signed [SUM_BITS-1:0] ACC_MIN = -ACC_MAX - SUM_BITS'(1);

    logic signed [ACC_BITS-1:0] acc_reg, acc_next;
    logic                       clip_reg, clip_next;
    logic [ROW_NUM_BITS-1:0]    row_cnt_reg, row_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    out_word_t                  m_word_reg, m_word_next;

    logic signed [SUM_BITS-1:0] sum;
    logic signed [ACC_BITS-1:0] acc_sat;
    logic                       clip_now;
    logic                       emits;
    logic                       step;

    assign emits = in_ctrl.valid &&
                   ((in_ctrl.func == FUNC_NONZERO && in_ctrl.row_end) ||
                    in_ctrl.func == FUNC_EMPTY);
    assign hold  = emits && m_valid_reg && !m_ready;
    assign step  = en && in_ctrl.valid;

    always_comb begin
        sum = SUM_BITS'(acc_reg) + SUM_BITS'(in_product);
        if (sum > ACC_MAX) begin
            acc_sat  = ACC_BITS'(ACC_MAX);
            clip_now = 1'b1;
        end else if (sum < ACC_MIN) begin
            acc_sat  = ACC_BITS'(ACC_MIN);
            clip_now = 1'b1;
        end else begin
            acc_sat  = ACC_BITS'(sum);
            clip_now = 1'b0;
        end
    end

    always_comb begin
        acc_next     = acc_reg;
        clip_next    = clip_reg;
        row_cnt_next = row_cnt_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (step) begin
            case (in_ctrl.func)
                FUNC_LOAD: begin
                    row_cnt_next = '0;
                end
                FUNC_NONZERO: begin
                    if (in_ctrl.row_end) begin
                        m_word_next.row_sum    = ROW_SUM_BITS'($unsigned(acc_sat));
                        m_word_next.row_number = row_cnt_reg;
                        m_word_next.saturated  = clip_reg || clip_now;
                        m_valid_next           = 1'b1;
                        row_cnt_next           = row_cnt_reg + 1'b1;
                        acc_next               = '0;
                        clip_next              = 1'b0;
                    end else begin
                        acc_next  = acc_sat;
                        clip_next = clip_reg || clip_now;
                    end
                end
                FUNC_EMPTY: begin
                    m_word_next.row_sum    = '0;
                    m_word_next.row_number = row_cnt_reg;
                    m_word_next.saturated  = 1'b0;
                    m_valid_next           = 1'b1;
                    row_cnt_next           = row_cnt_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
            row_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            clip_reg    <= clip_next;
            row_cnt_reg <= row_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    a_hold_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        hold |-> (m_valid_reg && !m_ready))
        else $error("stall without a waiting output word");

    a_row_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_ctrl.func == FUNC_NONZERO && in_ctrl.row_end)
        |=> (acc_reg == '0 && !clip_reg && m_valid_reg))
        else $error("row end did not clear accumulator or raise output");

    a_load_clears_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_ctrl.func == FUNC_LOAD) |=> (row_cnt_reg == '0))
        else $error("vector load did not clear row counter");

    a_clip_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_ctrl.func == FUNC_NONZERO && !in_ctrl.row_end && clip_now)
        |=> (clip_reg && (acc_reg == ACC_BITS'(ACC_MAX) || acc_reg == ACC_BITS'(ACC_MIN))))
        else $error("saturation left accumulator off its limit");

endmodule

[hw/rtl/csr_sparse_matvec.sv]
// ----------------------------------------------------------------------------
// csr_sparse_matvec
// sparse matrix-vector product over a csr nonzero stream
// ----------------------------------------------------------------------------
// The block takes one input word per cycle while s_ready is high. Load words
// write the dense vector into an on-chip ram; nonzero words read their column
// from that ram, pass through one multiplier and land in a saturating
// accumulator, and a row end or empty-row word raises a result word after it
// passes the input stage, product and output word registers. The sustained
// rate is one word per cycle, set by the single ram read port and the one
// multiplier; s_ready drops only for a cycle in which a result is due while
// the previous output word is still waiting to be taken. The vector ram has
// no reset, every entry must be loaded before it is used.
// ----------------------------------------------------------------------------
module csr_sparse_matvec #(
    parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
    parameter int OPERAND_BITS = csrmv_pkg::OPERAND_BITS_DEF,
    parameter int ACC_BITS     = csrmv_pkg::ACC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  csrmv_pkg::in_word_t  s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output csrmv_pkg::out_word_t m_word
);
    import csrmv_pkg::*;

    localparam int ADDR_BITS = $clog2(VECTOR_DEPTH);

    logic                              en;
    logic                              hold;
    logic                              accept;
    logic                              in_range;
    logic [ADDR_BITS-1:0]              addr;
    logic [OPERAND_BITS-1:0]           operand;
    logic [OPERAND_BITS-1:0]           entry;
    stage_ctrl_t                       s1_ctrl_reg, s1_ctrl_next;
    logic [OPERAND_BITS-1:0]           s1_value_reg;
    logic                              s1_hit_reg;
    stage_ctrl_t                       s2_ctrl;
    logic signed [2*OPERAND_BITS-1:0]  s2_product;

    assign en       = !hold;
    assign s_ready  = en;
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_word.index) < 32'(VECTOR_DEPTH));
    assign addr     = ADDR_BITS'(s_word.index);
    assign operand  = OPERAND_BITS'($unsigned(s_word.value));

    csrmv_ram #(
        .WIDTH (OPERAND_BITS),
        .DEPTH (VECTOR_DEPTH)
    ) u_vector_ram (
        .aclk  (aclk),
        .we    (accept && s_word.func == FUNC_LOAD && in_range),
        .waddr (addr),
        .wdata (operand),
        .re    (en),
        .raddr (addr),
        .rdata (entry)
    );

    always_comb begin
        s1_ctrl_next.valid   = accept;
        s1_ctrl_next.func    = s_word.func;
        s1_ctrl_next.row_end = s_word.row_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctrl_reg <= '0;
        end else if (en) begin
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_value_reg <= operand;
            s1_hit_reg   <= in_range;
        end
    end

    csrmv_mul #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_mul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_ctrl     (s1_ctrl_reg),
        .in_value    (s1_value_reg),
        .in_entry    (entry),
        .in_hit      (s1_hit_reg),
        .out_ctrl    (s2_ctrl),
        .out_product (s2_product)
    );

    csrmv_acc #(
        .OPERAND_BITS (OPERAND_BITS),
        .ACC_BITS     (ACC_BITS)
    ) u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_ctrl    (s2_ctrl),
        .in_product (s2_product),
        .hold       (hold),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

endmodule
